/* design/fes_pkg.sv */
// Shared types and constants for the fade envelope scheduler.
package fes_pkg;

   localparam int unsigned MAX_RESULTS = 64;
   localparam int unsigned CNT_W       = 7;

   localparam logic CMD_SPAWN = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_FADE_IN  = 2'd1,
      PH_HOLD     = 2'd2,
      PH_FADE_OUT = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SP_SCAN,
      ST_A_SCAN,
      ST_A_EVAL,
      ST_B_SCAN,
      ST_B_EVAL,
      ST_DIV,
      ST_PUSH,
      ST_FLUSH
   } ctrl_state_type;

   typedef struct packed {
      logic        command;
      logic [31:0] now_ms;
      logic [7:0]  handle;
      logic [7:0]  base_opacity;
      logic [15:0] fade_in_ms;
      logic [19:0] hold_ms;
      logic [15:0] fade_out_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] out_handle;
      logic [7:0] opacity;
      logic       released;
      logic       dropped;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] time_ms;
      logic [7:0]  base;
      logic [15:0] fade_in;
      logic [19:0] hold;
      logic [15:0] fade_out;
   } slot_type;

   typedef struct packed {
      logic load;
      logic idx_clr;
      logic idx_inc;
      logic spawn;
      logic drop;
      logic ev_a;
      logic ev_b;
      logic div_step;
      logic push_div;
      logic flush;
   } cmd_type;

   typedef struct packed {
      phase_type phase_cur;
      logic      idx_last;
      logic      start_tick;
      logic      ev_div_a;
      logic      ev_div_b;
      logic      div_last;
   } status_type;

endpackage

/* design/fes_datapath.sv */
// Slot store, phase flags, divider and result buffering of the scheduler.
module fes_datapath #(
   parameter int unsigned SLOTS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  fes_pkg::req_type    req_data,
   input  fes_pkg::cmd_type    cmd,
   output fes_pkg::status_type st,
   output logic                rsp_valid,
   output fes_pkg::rsp_type    rsp_data
);

   localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   fes_pkg::req_type   req_ff;
   fes_pkg::phase_type phase_ff [SLOTS];
   fes_pkg::slot_type  mem [SLOTS];
   fes_pkg::slot_type  rd_ff;
   logic [IdxW-1:0]    idx_ff;

   logic [15:0] rem_ff, den_ff;
   logic [7:0]  nlo_ff, quo_ff;
   logic [2:0]  dcnt_ff;

   fes_pkg::rsp_type   pend_ff;
   logic               pend_v_ff;
   logic [fes_pkg::CNT_W-1:0] n_ff;
   logic               rsp_valid_ff;
   fes_pkg::rsp_type   rsp_ff;
   fes_pkg::rsp_type   out_val;

   fes_pkg::phase_type cur_ph;
   logic [31:0] e_val, new_t;
   logic [15:0] m_a, fout_m;
   logic        a_move, a_hold_done, b_rel;
   logic [23:0] num;
   logic [16:0] dv_t;
   logic        dv_ge;

   logic               we;
   fes_pkg::slot_type  wdata;
   logic               ph_we;
   fes_pkg::phase_type ph_wdata;
   logic               push_en;
   fes_pkg::rsp_type   push_val;
   logic               room;

   assign cur_ph = phase_ff[idx_ff];

   // evaluate the slot just read
   always_comb begin
      e_val       = req_ff.now_ms - rd_ff.time_ms;
      m_a         = (e_val < 32'(rd_ff.fade_in)) ? e_val[15:0] : rd_ff.fade_in;
      a_move      = e_val > 32'(rd_ff.fade_in);
      new_t       = rd_ff.time_ms + 32'(rd_ff.fade_in) + 32'(rd_ff.hold);
      a_hold_done = rd_ff.time_ms < req_ff.now_ms;
      b_rel       = e_val > 32'(rd_ff.fade_out);
      fout_m      = rd_ff.fade_out - e_val[15:0];
      num         = cmd.ev_b ? (24'(rd_ff.base) * 24'(fout_m))
                             : (24'(rd_ff.base) * 24'(m_a));
   end

   assign st.phase_cur  = cur_ph;
   assign st.idx_last   = (idx_ff == IdxW'(SLOTS - 1));
   assign st.start_tick = (req_data.command == fes_pkg::CMD_TICK);
   assign st.ev_div_a   = (cur_ph == fes_pkg::PH_FADE_IN) && (rd_ff.fade_in != 16'd0);
   assign st.ev_div_b   = !b_rel && (rd_ff.fade_out != 16'd0);
   assign st.div_last   = (dcnt_ff == 3'd7);

   // decide store, phase and result updates
   always_comb begin
      we       = 1'b0;
      wdata    = rd_ff;
      ph_we    = 1'b0;
      ph_wdata = cur_ph;
      push_en  = 1'b0;
      push_val = '0;
      if (cmd.spawn) begin
         we             = 1'b1;
         ph_we          = 1'b1;
         wdata.handle   = req_ff.handle;
         wdata.base     = req_ff.base_opacity;
         wdata.fade_in  = req_ff.fade_in_ms;
         wdata.hold     = req_ff.hold_ms;
         wdata.fade_out = req_ff.fade_out_ms;
         wdata.time_ms  = req_ff.now_ms;
         if (req_ff.fade_in_ms != 16'd0) begin
            ph_wdata = fes_pkg::PH_FADE_IN;
         end else if (req_ff.hold_ms != 20'd0) begin
            ph_wdata      = fes_pkg::PH_HOLD;
            wdata.time_ms = req_ff.now_ms + 32'(req_ff.hold_ms);
         end else begin
            ph_wdata = fes_pkg::PH_FADE_OUT;
         end
         push_en             = 1'b1;
         push_val.out_handle = req_ff.handle;
         push_val.opacity    = req_ff.base_opacity;
      end else if (cmd.drop) begin
         push_en             = 1'b1;
         push_val.out_handle = req_ff.handle;
         push_val.dropped    = 1'b1;
      end else if (cmd.ev_a) begin
         if (cur_ph == fes_pkg::PH_FADE_IN) begin
            if (rd_ff.fade_in == 16'd0) begin
               push_en             = 1'b1;
               push_val.out_handle = rd_ff.handle;
               push_val.opacity    = rd_ff.base;
            end
            if (a_move) begin
               we            = 1'b1;
               wdata.time_ms = new_t;
               ph_we         = 1'b1;
               ph_wdata      = (new_t < req_ff.now_ms) ? fes_pkg::PH_FADE_OUT
                                                       : fes_pkg::PH_HOLD;
            end
         end else if (a_hold_done) begin
            ph_we    = 1'b1;
            ph_wdata = fes_pkg::PH_FADE_OUT;
         end
      end else if (cmd.ev_b) begin
         if (b_rel) begin
            ph_we             = 1'b1;
            ph_wdata          = fes_pkg::PH_FREE;
            push_en           = 1'b1;
            push_val.released = 1'b1;
         end else if (rd_ff.fade_out == 16'd0) begin
            push_en = 1'b1;
         end
         push_val.out_handle = rd_ff.handle;
      end else if (cmd.push_div) begin
         push_en             = 1'b1;
         push_val.out_handle = rd_ff.handle;
         push_val.opacity    = quo_ff;
      end
   end

   // hold the request and walk the slot index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + IdxW'(1);
      end
   end

   // phase flags, all free after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            phase_ff[i] <= fes_pkg::PH_FREE;
         end
      end else if (ph_we) begin
         phase_ff[idx_ff] <= ph_wdata;
      end
   end

   // slot store with registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[idx_ff] <= wdata;
      end
      rd_ff <= mem[idx_ff];
   end

   // restoring divider, one quotient bit per cycle
   assign dv_t  = {rem_ff, nlo_ff[7]};
   assign dv_ge = dv_t >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if ((cmd.ev_a && st.ev_div_a) || (cmd.ev_b && st.ev_div_b)) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 3'd1;
      end
      if (cmd.ev_a || cmd.ev_b) begin
         rem_ff <= num[23:8];
         nlo_ff <= num[7:0];
         den_ff <= cmd.ev_b ? rd_ff.fade_out : rd_ff.fade_in;
      end else if (cmd.div_step) begin
         rem_ff <= dv_ge ? 16'(dv_t - {1'b0, den_ff}) : dv_t[15:0];
         nlo_ff <= {nlo_ff[6:0], 1'b0};
         quo_ff <= {quo_ff[6:0], dv_ge};
      end
   end

   // keep one result back so the final one can carry last
   assign room = (n_ff < fes_pkg::CNT_W'(fes_pkg::MAX_RESULTS));

   always_comb begin
      out_val      = pend_ff;
      out_val.last = cmd.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (cmd.flush) begin
            rsp_valid_ff <= pend_v_ff;
            rsp_ff       <= out_val;
            pend_v_ff    <= 1'b0;
            n_ff         <= '0;
         end else if (push_en && room) begin
            rsp_valid_ff <= pend_v_ff;
            rsp_ff       <= out_val;
            pend_ff      <= push_val;
            pend_v_ff    <= 1'b1;
            n_ff         <= n_ff + fes_pkg::CNT_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/fes_ctrl.sv */
// Sequencer that walks the slots for spawns and ticks.
module fes_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  fes_pkg::status_type st,
   output fes_pkg::cmd_type    cmd,
   output logic                busy
);

   fes_pkg::ctrl_state_type state_ff, state_in;
   logic pass_b_ff, pass_b_in;

   fes_pkg::ctrl_state_type adv_state;
   logic adv_clr, adv_inc, adv_passb;

   // register state and pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= fes_pkg::ST_IDLE;
         pass_b_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pass_b_ff <= pass_b_in;
      end
   end

   // step to the next slot or the next pass
   always_comb begin
      adv_clr   = 1'b0;
      adv_inc   = 1'b0;
      adv_passb = pass_b_ff;
      if (!pass_b_ff) begin
         if (st.idx_last) begin
            adv_state = fes_pkg::ST_B_SCAN;
            adv_clr   = 1'b1;
            adv_passb = 1'b1;
         end else begin
            adv_state = fes_pkg::ST_A_SCAN;
            adv_inc   = 1'b1;
         end
      end else if (st.idx_last) begin
         adv_state = fes_pkg::ST_FLUSH;
      end else begin
         adv_state = fes_pkg::ST_B_SCAN;
         adv_inc   = 1'b1;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      pass_b_in = pass_b_ff;
      cmd       = '0;
      case (state_ff)
         fes_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load    = 1'b1;
               cmd.idx_clr = 1'b1;
               pass_b_in   = 1'b0;
               state_in    = st.start_tick ? fes_pkg::ST_A_SCAN : fes_pkg::ST_SP_SCAN;
            end
         end
         fes_pkg::ST_SP_SCAN: begin
            if (st.phase_cur == fes_pkg::PH_FREE) begin
               cmd.spawn = 1'b1;
               state_in  = fes_pkg::ST_FLUSH;
            end else if (st.idx_last) begin
               cmd.drop = 1'b1;
               state_in = fes_pkg::ST_FLUSH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         fes_pkg::ST_A_SCAN: begin
            if (st.phase_cur == fes_pkg::PH_FADE_IN || st.phase_cur == fes_pkg::PH_HOLD) begin
               state_in = fes_pkg::ST_A_EVAL;
            end else begin
               state_in    = adv_state;
               cmd.idx_clr = adv_clr;
               cmd.idx_inc = adv_inc;
               pass_b_in   = adv_passb;
            end
         end
         fes_pkg::ST_A_EVAL: begin
            cmd.ev_a = 1'b1;
            if (st.ev_div_a) begin
               state_in = fes_pkg::ST_DIV;
            end else begin
               state_in    = adv_state;
               cmd.idx_clr = adv_clr;
               cmd.idx_inc = adv_inc;
               pass_b_in   = adv_passb;
            end
         end
         fes_pkg::ST_B_SCAN: begin
            if (st.phase_cur == fes_pkg::PH_FADE_OUT) begin
               state_in = fes_pkg::ST_B_EVAL;
            end else begin
               state_in    = adv_state;
               cmd.idx_clr = adv_clr;
               cmd.idx_inc = adv_inc;
               pass_b_in   = adv_passb;
            end
         end
         fes_pkg::ST_B_EVAL: begin
            cmd.ev_b = 1'b1;
            if (st.ev_div_b) begin
               state_in = fes_pkg::ST_DIV;
            end else begin
               state_in    = adv_state;
               cmd.idx_clr = adv_clr;
               cmd.idx_inc = adv_inc;
               pass_b_in   = adv_passb;
            end
         end
         fes_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               state_in = fes_pkg::ST_PUSH;
            end
         end
         fes_pkg::ST_PUSH: begin
            cmd.push_div = 1'b1;
            state_in     = adv_state;
            cmd.idx_clr  = adv_clr;
            cmd.idx_inc  = adv_inc;
            pass_b_in    = adv_passb;
         end
         fes_pkg::ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = fes_pkg::ST_IDLE;
         end
         default: begin
            state_in = fes_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != fes_pkg::ST_IDLE);

endmodule

/* design/fade_envelope_scheduler.sv */
// Top level of the fade envelope scheduler.
// Takes one request at a time while busy is low. A spawn scans the slots
// lowest first, one slot a cycle. A tick makes two walks over the slots: a
// slot with nothing to do is only scanned, an examined slot is also
// evaluated, and one that needs an opacity quotient then goes through the
// shared one-bit-per-cycle divider before its result is pushed; a flush
// step ends the request. Results leave on rsp_valid and cannot be held off;
// the last result of a request carries last and is on the ports in the first
// cycle that busy is low again.
module fade_envelope_scheduler #(
   parameter int unsigned SLOTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fes_pkg::req_type req_data,
   output logic             rsp_valid,
   output fes_pkg::rsp_type rsp_data
);

   fes_pkg::cmd_type    cmd;
   fes_pkg::status_type st;

   fes_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .st    (st),
      .cmd   (cmd),
      .busy  (busy)
   );

   fes_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .st        (st),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/fes_checker.sv */
// Port-level checks for the fade envelope scheduler, bound to the top level.
module fes_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input fes_pkg::rsp_type rsp_data,
   input logic             rsp_valid
);

   // a taken request occupies the block
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise after request");

   // released and dropped never together
   a_rel_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.released && rsp_data.dropped))
      else $error("released and dropped both set");

   // dropped and released results carry zero opacity
   a_zero_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.released || rsp_data.dropped) |-> rsp_data.opacity == 8'd0)
      else $error("nonzero opacity on release or drop");

   // a dropped result ends its request
   a_drop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> rsp_data.last)
      else $error("dropped result not last");

endmodule

bind fade_envelope_scheduler fes_checker u_fes_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

/* tb/testbench.sv */
// Self-checking testbench for the fade envelope scheduler.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned NUM_SLOTS  = 32;
   localparam int unsigned IDLE_LIMIT = 6000;
   localparam int unsigned SETTLE     = 800;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   fes_pkg::req_type req_data;
   logic             rsp_valid;
   fes_pkg::rsp_type rsp_data;

   // predictor copy of the slot table
   fes_pkg::phase_type env_phase    [NUM_SLOTS];
   logic [7:0]         env_handle   [NUM_SLOTS];
   logic [31:0]        env_time     [NUM_SLOTS];
   logic [7:0]         env_base     [NUM_SLOTS];
   logic [15:0]        env_fade_in  [NUM_SLOTS];
   logic [19:0]        env_hold     [NUM_SLOTS];
   logic [15:0]        env_fade_out [NUM_SLOTS];

   fes_pkg::rsp_type pending_opacity[$];
   int unsigned      mismatches = 0;
   int unsigned      idle_cycles = 0;
   logic [31:0]      now_clock;

   fade_envelope_scheduler #(.SLOTS(NUM_SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Work out the results that one request causes and queue them
   task automatic predict_envelopes(input fes_pkg::req_type r);
      fes_pkg::rsp_type res[$];
      fes_pkg::rsp_type one;
      int               free_idx;
      logic [31:0]      el;
      logic [31:0]      m;
      logic [39:0]      prod;
      free_idx = -1;
      one = '0;
      if (r.command == fes_pkg::CMD_SPAWN) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (free_idx < 0 && env_phase[i] == fes_pkg::PH_FREE) free_idx = i;
         end
         one.out_handle = r.handle;
         if (free_idx < 0) begin
            one.dropped = 1'b1;
         end else begin
            one.opacity = r.base_opacity;
            env_handle[free_idx]   = r.handle;
            env_base[free_idx]     = r.base_opacity;
            env_fade_in[free_idx]  = r.fade_in_ms;
            env_hold[free_idx]     = r.hold_ms;
            env_fade_out[free_idx] = r.fade_out_ms;
            if (r.fade_in_ms != 0) begin
               env_phase[free_idx] = fes_pkg::PH_FADE_IN;
               env_time[free_idx]  = r.now_ms;
            end else if (r.hold_ms != 0) begin
               env_phase[free_idx] = fes_pkg::PH_HOLD;
               env_time[free_idx]  = r.now_ms + 32'(r.hold_ms);
            end else begin
               env_phase[free_idx] = fes_pkg::PH_FADE_OUT;
               env_time[free_idx]  = r.now_ms;
            end
         end
         res = {res, one};
      end else begin
         // fade-in walk
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (env_phase[i] == fes_pkg::PH_FADE_IN) begin
               el = r.now_ms - env_time[i];
               one = '0;
               one.out_handle = env_handle[i];
               if (env_fade_in[i] == 0) begin
                  one.opacity = env_base[i];
               end else begin
                  m = (el < 32'(env_fade_in[i])) ? el : 32'(env_fade_in[i]);
                  prod = 40'(env_base[i]) * 40'(m);
                  one.opacity = 8'(prod / 40'(env_fade_in[i]));
               end
               if (res.size() < fes_pkg::MAX_RESULTS) res = {res, one};
               if (el > 32'(env_fade_in[i])) begin
                  env_time[i]  = env_time[i] + 32'(env_fade_in[i]) + 32'(env_hold[i]);
                  env_phase[i] = fes_pkg::PH_HOLD;
               end
            end
         end
         // advance expired holds
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (env_phase[i] == fes_pkg::PH_HOLD && env_time[i] < r.now_ms) begin
               env_phase[i] = fes_pkg::PH_FADE_OUT;
            end
         end
         // fade-out walk
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (env_phase[i] == fes_pkg::PH_FADE_OUT) begin
               el = r.now_ms - env_time[i];
               one = '0;
               one.out_handle = env_handle[i];
               if (el > 32'(env_fade_out[i])) begin
                  env_phase[i] = fes_pkg::PH_FREE;
                  one.released = 1'b1;
               end else if (env_fade_out[i] != 0) begin
                  prod = 40'(env_base[i]) * 40'(32'(env_fade_out[i]) - el);
                  one.opacity = 8'(prod / 40'(env_fade_out[i]));
               end
               if (res.size() < fes_pkg::MAX_RESULTS) res = {res, one};
            end
         end
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[k]) pending_opacity = {pending_opacity, res[k]};
   endtask

   // Send one request, then hold start low for gap cycles
   task automatic send_request(input fes_pkg::req_type r, input int unsigned gap);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_envelopes(r);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic fes_pkg::req_type make_spawn(input logic [31:0] t,
                                                   input logic [7:0] h,
                                                   input logic [7:0] b,
                                                   input logic [15:0] fi,
                                                   input logic [19:0] ho,
                                                   input logic [15:0] fo);
      fes_pkg::req_type r;
      r = '0;
      r.command      = fes_pkg::CMD_SPAWN;
      r.now_ms       = t;
      r.handle       = h;
      r.base_opacity = b;
      r.fade_in_ms   = fi;
      r.hold_ms      = ho;
      r.fade_out_ms  = fo;
      return r;
   endfunction

   function automatic fes_pkg::req_type make_tick(input logic [31:0] t);
      fes_pkg::req_type r;
      logic [127:0]     raw;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      r = raw[$bits(fes_pkg::req_type)-1:0];
      r.command = fes_pkg::CMD_TICK;
      r.now_ms  = t;
      return r;
   endfunction

   // Wait until every expected result has come and the block is idle
   task automatic drain_all();
      start <= 1'b0;
      @(posedge clock);
      while (pending_opacity.size() > 0 || busy) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(make_spawn(32'd1000, 8'd1, 8'd255, 16'd100, 20'd50, 16'd100), 0);
      send_request(make_spawn(32'd1000, 8'd2, 8'd0, 16'd0, 20'd200, 16'd0), 1);
      send_request(make_spawn(32'd1000, 8'd3, 8'd128, 16'd0, 20'd0, 16'd0), 0);
      send_request(make_spawn(32'd1000, 8'd4, 8'd200, 16'd0, 20'd0, 16'd300), 2);
      send_request(make_tick(32'd1000), 0);
      send_request(make_tick(32'd1050), 0);
      send_request(make_tick(32'd1100), 1);
      send_request(make_tick(32'd1101), 0);
      send_request(make_tick(32'd1151), 0);
      send_request(make_tick(32'd1201), 0);
      send_request(make_tick(32'd1250), 0);
      send_request(make_tick(32'd1301), 0);
      send_request(make_tick(32'd1400), 0);
      // fade-in that runs past its end and its hold in one tick
      send_request(make_spawn(32'd2000, 8'd5, 8'd77, 16'd10, 20'd5, 16'd20), 0);
      send_request(make_tick(32'd2030), 0);
      send_request(make_tick(32'd2100), 0);
      // widest fields with the hold deadline wrapping
      send_request(make_spawn(32'hFFFF_FF00, 8'hFF, 8'hFF, 16'hFFFF, 20'hF_FFFF,
                              16'hFFFF), 0);
      send_request(make_spawn(32'hFFFF_FF00, 8'h00, 8'hFF, 16'h0000, 20'hF_FFFF,
                              16'hFFFF), 0);
      send_request(make_tick(32'hFFFF_FFFF), 0);
      send_request(make_tick(32'h0000_8000), 0);
      send_request(make_tick(32'h0020_0000), 0);
      send_request(make_tick(32'h0030_0000), 0);
      drain_all();
   endtask

   task automatic test_full_table();
      for (int i = 0; i < NUM_SLOTS + 3; i++) begin
         send_request(make_spawn(32'd5000, 8'($urandom()), 8'($urandom()), 16'd0,
                                 20'd400, 16'd0), pick_gap());
      end
      send_request(make_tick(32'd5300), 0);
      send_request(make_tick(32'd5401), 0);
      send_request(make_tick(32'd5402), 0);
      // wait for the last results; the ticks above have emptied the table
      drain_all();
      now_clock = 32'd6000;
   endtask

   task automatic test_random();
      fes_pkg::req_type r;
      logic [127:0]     raw;
      int unsigned      roll;
      for (int n = 0; n < 200; n++) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            raw = {$urandom(), $urandom(), $urandom(), $urandom()};
            r = raw[$bits(fes_pkg::req_type)-1:0];
            r.command = fes_pkg::CMD_SPAWN;
            r.now_ms  = now_clock;
            if ($urandom_range(9) != 0) begin
               r.fade_in_ms  = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(200));
               r.hold_ms     = ($urandom_range(3) == 0) ? 20'd0 : 20'($urandom_range(300));
               r.fade_out_ms = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(200));
            end
         end else begin
            roll = $urandom_range(99);
            if (roll < 4) now_clock = $urandom();
            else if (roll < 10) now_clock = now_clock + $urandom_range(2_200_000, 70_000);
            else now_clock = now_clock + $urandom_range(120);
            r = make_tick(now_clock);
         end
         send_request(r, pick_gap());
      end
      drain_all();
   endtask

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      fes_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_opacity.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            want = pending_opacity.pop_front();
            if (rsp_data !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, rsp_data);
            end
         end
      end
   end

   // Abort when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      now_clock   = 32'd0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         env_phase[i]    = fes_pkg::PH_FREE;
         env_handle[i]   = '0;
         env_time[i]     = '0;
         env_base[i]     = '0;
         env_fade_in[i]  = '0;
         env_hold[i]     = '0;
         env_fade_out[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && pending_opacity.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/fes_pkg.sv
design/fes_datapath.sv
design/fes_ctrl.sv
design/fade_envelope_scheduler.sv
design/fes_checker.sv
tb/testbench.sv
